/* design/fhsd_pkg.sv */
package fhsd_pkg;

	// Default width of the delay registers and the tick counters; the heat-on counter is two bits wider
	localparam int DELAY_WIDTH_DEF = 12;

	// Configuration register map
	localparam int CFG_REGS        = 6;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAN_LOW_ON   = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAN_LOW_OFF  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAN_HIGH_ON  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAN_HIGH_OFF = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_STAGE1_ON    = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_STAGE2_ON    = 3'd5;

	// Reset values of the delay registers, in ticks, one per register index
	localparam logic [CFG_REGS-1:0][15:0] CFG_RESET = {
		16'd17,   // stage two on
		16'd15,   // stage one on
		16'd15,   // high fan off
		16'd5,    // high fan on
		16'd15,   // low fan off
		16'd5     // low fan on
	};

	// Input operation codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_FAN  = 2'd1;
	localparam logic [1:0] OP_HEAT = 2'd2;

	// Relay bit positions
	localparam int RLY_FAN_LOW  = 0;
	localparam int RLY_FAN_HIGH = 1;
	localparam int RLY_STAGE1   = 2;
	localparam int RLY_STAGE2   = 3;
	localparam int RELAYS       = 4;

	localparam int IN_DATA_WIDTH  = 8;
	localparam int OUT_DATA_WIDTH = 8;

	typedef enum logic [1:0] {
		REQ_IDLE = 2'd0,
		REQ_ON   = 2'd1,
		REQ_OFF  = 2'd2
	} req_t;

	// Packed to match the output tdata layout, relays in the low bits
	typedef struct packed {
		req_t              heat_req;
		req_t              fan_req;
		logic [RELAYS-1:0] relays;
	} result_t;

endpackage

/* design/fhsd_cfg.sv */
module fhsd_cfg #(
	parameter int DELAY_WIDTH = fhsd_pkg::DELAY_WIDTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            wr_en,
	input  logic [fhsd_pkg::CFG_INDEX_WIDTH-1:0]            wr_index,
	input  logic [DELAY_WIDTH-1:0]                          wr_data,
	output logic [fhsd_pkg::CFG_REGS-1:0][DELAY_WIDTH-1:0]  delays
);
	import fhsd_pkg::*;

	logic [CFG_REGS-1:0][DELAY_WIDTH-1:0] delay_q;

	for (genvar i = 0; i < CFG_REGS; i++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				delay_q[i] <= DELAY_WIDTH'(CFG_RESET[i]);
			end else if (wr_en && wr_index == CFG_INDEX_WIDTH'(i)) begin
				delay_q[i] <= wr_data;
			end
		end
	end

	assign delays = delay_q;

endmodule

/* design/fhsd_core.sv */
module fhsd_core #(
	parameter int DELAY_WIDTH = fhsd_pkg::DELAY_WIDTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            step_en,
	input  logic [1:0]                                      op,
	input  logic                                            pin_level,
	input  logic [fhsd_pkg::CFG_REGS-1:0][DELAY_WIDTH-1:0]  delays,
	output fhsd_pkg::result_t                               result
);
	import fhsd_pkg::*;

	localparam int SUM_WIDTH = DELAY_WIDTH + 2;

	req_t                   fan_req_q, heat_req_q, fan_req_d, heat_req_d;
	logic [DELAY_WIDTH-1:0] fan_on_q, fan_off_q, heat_off_q;
	logic [DELAY_WIDTH-1:0] fan_on_d, fan_off_d, heat_off_d;
	logic [SUM_WIDTH-1:0]   heat_on_q, heat_on_d, on_sum;
	logic [RELAYS-1:0]      relay_q, relay_d;

	assign on_sum = SUM_WIDTH'(delays[REG_FAN_HIGH_ON]) + SUM_WIDTH'(delays[REG_STAGE1_ON])
		+ SUM_WIDTH'(delays[REG_STAGE2_ON]);

	always_comb begin
		fan_req_d  = fan_req_q;
		heat_req_d = heat_req_q;
		fan_on_d   = fan_on_q;
		fan_off_d  = fan_off_q;
		heat_on_d  = heat_on_q;
		heat_off_d = heat_off_q;
		relay_d    = relay_q;
		unique case (op)
			OP_TICK: begin
				// low fan on, held back while high fan runs
				if (fan_req_q == REQ_ON && !relay_q[RLY_FAN_HIGH]) begin
					fan_on_d = fan_on_q + 1'b1;
					if (fan_on_d >= delays[REG_FAN_LOW_ON]) begin
						relay_d[RLY_FAN_LOW] = 1'b1;
						fan_req_d            = REQ_IDLE;
						fan_on_d             = '0;
					end
				end
				if (fan_req_q == REQ_OFF) begin
					fan_off_d = fan_off_q + 1'b1;
					if (fan_off_d >= delays[REG_FAN_LOW_OFF]) begin
						relay_d[RLY_FAN_LOW] = 1'b0;
						fan_req_d            = REQ_IDLE;
						fan_off_d            = '0;
					end
				end
				// heat on: drop low fan, stage in high fan and heaters
				if (heat_req_q == REQ_ON) begin
					relay_d[RLY_FAN_LOW] = 1'b0;
					fan_on_d             = '0;
					fan_off_d            = '0;
					heat_on_d            = heat_on_q + 1'b1;
					if (heat_on_d >= SUM_WIDTH'(delays[REG_FAN_HIGH_ON]))
						relay_d[RLY_FAN_HIGH] = 1'b1;
					if (heat_on_d >= SUM_WIDTH'(delays[REG_STAGE1_ON]))
						relay_d[RLY_STAGE1] = 1'b1;
					if (heat_on_d >= SUM_WIDTH'(delays[REG_STAGE2_ON]))
						relay_d[RLY_STAGE2] = 1'b1;
					if (heat_on_d >= on_sum) begin
						heat_req_d = REQ_IDLE;
						heat_on_d  = '0;
					end
				end
				// heat off: heaters drop at once, high fan after its delay
				if (heat_req_q == REQ_OFF) begin
					relay_d[RLY_STAGE1] = 1'b0;
					relay_d[RLY_STAGE2] = 1'b0;
					heat_off_d          = heat_off_q + 1'b1;
					if (heat_off_d >= delays[REG_FAN_HIGH_OFF]) begin
						relay_d[RLY_FAN_HIGH] = 1'b0;
						heat_req_d            = REQ_IDLE;
						heat_off_d            = '0;
					end
				end
			end
			OP_FAN:  fan_req_d  = pin_level ? REQ_ON : REQ_OFF;
			OP_HEAT: heat_req_d = pin_level ? REQ_ON : REQ_OFF;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_req_q  <= REQ_IDLE;
			heat_req_q <= REQ_IDLE;
			fan_on_q   <= '0;
			fan_off_q  <= '0;
			heat_on_q  <= '0;
			heat_off_q <= '0;
			relay_q    <= '0;
		end else if (step_en) begin
			fan_req_q  <= fan_req_d;
			heat_req_q <= heat_req_d;
			fan_on_q   <= fan_on_d;
			fan_off_q  <= fan_off_d;
			heat_on_q  <= heat_on_d;
			heat_off_q <= heat_off_d;
			relay_q    <= relay_d;
		end
	end

	assign result.heat_req = heat_req_d;
	assign result.fan_req  = fan_req_d;
	assign result.relays   = relay_d;

endmodule

/* design/fan_heat_staging_delay_relay.sv */
// Fan and heater staging relay controller.
//
// Input stream (s_*): one request per tick or pin event. s_tdata[1:0] is the
// op (tick, fan pin event, heat pin event, code 3 does nothing) and
// s_tdata[2] the sampled pin level. Pin events only record a request; each
// tick runs the fan-on, fan-off, heat-on and heat-off rules in that order.
// Output stream (m_*): one result per accepted request, the state after it:
// the four relay drives and the fan and heat request codes.
// Config channel (cfg_*): writes a delay register, always ready; an index
// beyond the last register is dropped. Write only while the block is idle.
//
// The result sits in the output register the cycle after its request is
// accepted. Throughput is one request per cycle while each result is taken,
// set by the single rule stage feeding the output register. A stalled receiver
// holds the result in place; s_tready then drops until the result is taken,
// and rises again in the same cycle as m_tready.
// Reset clears all requests, counters and relays, empties the output
// register and loads the default delays.
module fan_heat_staging_delay_relay #(
	parameter int DELAY_WIDTH = fhsd_pkg::DELAY_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// op [1:0], pin_level [2], zero fill [7:3]
	input  logic [fhsd_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// fan_low [0], fan_high [1], heat_stage1 [2], heat_stage2 [3],
	// fan_request_state [5:4], heat_request_state [7:6]
	output logic [fhsd_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fhsd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [DELAY_WIDTH-1:0]                cfg_data
);
	import fhsd_pkg::*;

	logic                                 in_fire;
	logic [CFG_REGS-1:0][DELAY_WIDTH-1:0] delays;
	result_t                              result;
	result_t                              result_q;
	logic                                 out_valid_q;

	// Accept a request whenever the output register is empty or drains now
	assign s_tready  = !out_valid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	fhsd_cfg #(
		.DELAY_WIDTH(DELAY_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.delays  (delays)
	);

	fhsd_core #(
		.DELAY_WIDTH(DELAY_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (in_fire),
		.op       (s_tdata[1:0]),
		.pin_level(s_tdata[2]),
		.delays   (delays),
		.result   (result)
	);

	// Output register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_WIDTH'(result_q);

endmodule

/* design/fhsd_checker.sv */
module fhsd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [fhsd_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready
);
	import fhsd_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// Every accepted request yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request produced no result");

	// No result appears without a request
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) && !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result without request");

endmodule

bind fan_heat_staging_delay_relay fhsd_checker u_fhsd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tdata (m_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);
